/* rtl/core/assert_macros.svh */
// Assertion macros shared by the particle update RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/pu_pkg.sv */
// Types, constants and helper functions for the particle update pipeline.
// No dependencies; imported by every pu_* module and the top level.
`timescale 1ns / 1ps

package pu_pkg;

  typedef enum logic [2:0] {
    KIND_STATIC   = 3'd0,
    KIND_GRAV     = 3'd1,
    KIND_SLOWGRAV = 3'd2,
    KIND_FIRE     = 3'd3,
    KIND_EXPLODE  = 3'd4,
    KIND_EXPLODE2 = 3'd5,
    KIND_BLOB     = 3'd6,
    KIND_BLOB2    = 3'd7
  } ptype_e;

  // register map
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_TIME   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CURRENT_TIME = 2'd2;

  localparam logic [11:0] GRAVITY_RESET = 12'd800;

  // ramp step multipliers (ramp += ft * k / 16) and expiry limits, Q4.12
  localparam logic [3:0]  RAMP_K_FIRE     = 4'd5;
  localparam logic [3:0]  RAMP_K_EXPLODE  = 4'd10;
  localparam logic [3:0]  RAMP_K_EXPLODE2 = 4'd15;
  localparam logic [15:0] RAMP_LIMIT_FIRE = 16'h6000;
  localparam logic [15:0] RAMP_LIMIT_EXPL = 16'h8000;

  // ceil(2^34 / 5): x / 5 == (x * RECIP5) >> 34 for any x below 2^32
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

  localparam logic [7:0] TAB_EXPLODE  [8] = '{8'h6f, 8'h6d, 8'h6b, 8'h69,
                                               8'h67, 8'h65, 8'h63, 8'h61};
  localparam logic [7:0] TAB_EXPLODE2 [8] = '{8'h6f, 8'h6e, 8'h6d, 8'h6c,
                                               8'h6b, 8'h6a, 8'h68, 8'h66};
  localparam logic [7:0] TAB_FIRE     [8] = '{8'h6d, 8'h6b, 8'h06, 8'h05,
                                               8'h04, 8'h03, 8'h00, 8'h00};

  localparam logic signed [39:0] SAT_MAX = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] SAT_MIN = 40'shFF_8000_0000;

  typedef struct packed {
    logic [15:0] ft;
    logic [11:0] grav;
    logic [39:0] now;
  } cfg_t;

  typedef struct packed {
    ptype_e         ptype;
    logic [15:0]    ramp;
    logic [7:0]     color;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [39:0]    death;
  } in_t;

  // after stage 1: products registered
  typedef struct packed {
    logic           removed;
    ptype_e         ptype;
    logic [15:0]    ramp;
    logic [7:0]     color;
    logic [15:0]    inc;
    logic [27:0]    gp;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][48:0] prod;
  } s1_t;

  // after stage 2: position and ramp done, velocity deltas ready
  typedef struct packed {
    logic           removed;
    logic           expire;
    logic [15:0]    ramp;
    logic [7:0]     color;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][35:0] delta;
    logic [24:0]    gz;
  } s2_t;

  typedef struct packed {
    logic           removed;
    logic           expire;
    logic [15:0]    ramp;
    logic [7:0]     color;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
  } out_t;

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] color_lut(input ptype_e t, input logic [2:0] idx);
    logic [7:0] c;
    case (t)
      KIND_FIRE:     c = TAB_FIRE[idx];
      KIND_EXPLODE:  c = TAB_EXPLODE[idx];
      KIND_EXPLODE2: c = TAB_EXPLODE2[idx];
      default:       c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/pu_prod_stage.sv */
// Stage 1: velocity * frame time products, ft * gravity, ramp step, death check.
// Depends on pu_pkg.
`timescale 1ns / 1ps

module pu_prod_stage import pu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  in_t  data_i,
  output logic valid_o,
  output s1_t  data_o
);

  logic valid_q;
  s1_t  s1_d, s1_q;
  logic [19:0] kmul;

  always_comb begin
    case (data_i.ptype)
      KIND_FIRE:     kmul = 20'(cfg_i.ft) * 20'(RAMP_K_FIRE);
      KIND_EXPLODE:  kmul = 20'(cfg_i.ft) * 20'(RAMP_K_EXPLODE);
      KIND_EXPLODE2: kmul = 20'(cfg_i.ft) * 20'(RAMP_K_EXPLODE2);
      default:       kmul = '0;
    endcase
  end

  always_comb begin
    s1_d.removed = data_i.death < cfg_i.now;
    s1_d.ptype   = data_i.ptype;
    s1_d.ramp    = data_i.ramp;
    s1_d.color   = data_i.color;
    s1_d.inc     = kmul[19:4];
    s1_d.gp      = 28'(cfg_i.ft) * 28'(cfg_i.grav);
    s1_d.pos     = data_i.pos;
    s1_d.vel     = data_i.vel;
    for (int i = 0; i < 3; i++) begin
      // operands widened first so the full signed product is kept
      s1_d.prod[i] = 49'($signed(data_i.vel[i])) * 49'($signed({1'b0, cfg_i.ft}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = s1_q;

endmodule

/* rtl/core/pu_update_stage.sv */
// Stage 2: position update, ramp and color, gravity term, per-type velocity deltas.
// Depends on pu_pkg.
`timescale 1ns / 1ps

module pu_update_stage import pu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  s1_t  data_i,
  output logic valid_o,
  output s2_t  data_o
);

  logic        valid_q;
  s2_t         s2_d, s2_q;
  logic [57:0] grav_prod;
  logic [23:0] grav;
  logic [2:0][39:0] pos_sum;
  logic [2:0][35:0] dv1, dv4;
  logic [16:0] ramp_sum;
  logic [15:0] ramp_sat;
  logic [15:0] limit;
  logic        ramp_type;
  logic        over;

  // ft * gravity / 20 = (gp / 4) / 5
  assign grav_prod = 58'(data_i.gp[27:2]) * 58'(RECIP5);
  assign grav      = grav_prod[57:34];

  assign ramp_sum  = {1'b0, data_i.ramp} + {1'b0, data_i.inc};
  assign ramp_sat  = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
  assign limit     = (data_i.ptype == KIND_FIRE) ? RAMP_LIMIT_FIRE : RAMP_LIMIT_EXPL;
  assign ramp_type = data_i.ptype inside {KIND_FIRE, KIND_EXPLODE, KIND_EXPLODE2};
  assign over      = ramp_sat >= limit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // floor shifts of the product are plain slices
      dv1[i]     = {{3{data_i.prod[i][48]}}, data_i.prod[i][48:16]};
      dv4[i]     = {data_i.prod[i][48], data_i.prod[i][48:14]};
      pos_sum[i] = {{8{data_i.pos[i][31]}}, data_i.pos[i]}
                 + {{7{dv1[i][32]}}, dv1[i][32:0]};
    end
  end

  always_comb begin
    s2_d.removed = data_i.removed;
    s2_d.expire  = 1'b0;
    s2_d.ramp    = data_i.ramp;
    s2_d.color   = data_i.color;
    s2_d.pos     = data_i.pos;
    s2_d.vel     = data_i.vel;
    s2_d.delta   = '0;
    s2_d.gz      = '0;
    if (!data_i.removed) begin
      for (int i = 0; i < 3; i++) begin
        s2_d.pos[i] = sat32($signed(pos_sum[i]));
      end
      if (ramp_type) begin
        s2_d.ramp = ramp_sat;
        if (over) begin
          s2_d.expire = 1'b1;
        end else begin
          s2_d.color = color_lut(data_i.ptype, ramp_sat[14:12]);
        end
      end
      case (data_i.ptype)
        KIND_STATIC: s2_d.gz = '0;
        KIND_FIRE:   s2_d.gz = {1'b0, grav};
        default:     s2_d.gz = 25'(-$signed({1'b0, grav}));
      endcase
      case (data_i.ptype)
        KIND_EXPLODE, KIND_BLOB: begin
          s2_d.delta = dv4;
        end
        KIND_EXPLODE2: begin
          for (int i = 0; i < 3; i++) begin
            s2_d.delta[i] = 36'(-$signed(dv1[i]));
          end
        end
        KIND_BLOB2: begin
          for (int i = 0; i < 2; i++) begin
            s2_d.delta[i] = 36'(-$signed(dv4[i]));
          end
        end
        default: begin
          s2_d.delta = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = s2_q;

endmodule

/* rtl/core/pu_vel_stage.sv */
// Stage 3: velocity sums and saturation into the output register.
// Depends on pu_pkg.
`timescale 1ns / 1ps

module pu_vel_stage import pu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  s2_t  data_i,
  output logic valid_o,
  output out_t data_o
);

  logic valid_q;
  out_t out_d, out_q;
  logic [2:0][39:0] vsum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsum[i] = {{8{data_i.vel[i][31]}}, data_i.vel[i]}
              + {{4{data_i.delta[i][35]}}, data_i.delta[i]};
    end
    vsum[2] = vsum[2] + {{15{data_i.gz[24]}}, data_i.gz};
  end

  always_comb begin
    out_d.removed = data_i.removed;
    out_d.expire  = data_i.expire;
    out_d.ramp    = data_i.ramp;
    out_d.color   = data_i.color;
    out_d.pos     = data_i.pos;
    for (int i = 0; i < 3; i++) begin
      out_d.vel[i] = sat32($signed(vsum[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

endmodule

/* rtl/core/particle_update_step.sv */
// Particle update step: config registers, three-stage pipeline, handshake.
// Depends on pu_pkg, pu_prod_stage, pu_update_stage, pu_vel_stage, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one particle record per word.
//   Output channel (out_valid_o / out_ready_i) gives one updated record per word,
//   in input order. Config channel (cfg_valid_i / cfg_ready_o) writes frame_time,
//   gravity or current_time by index; it is always ready, an unused index is
//   dropped. Write config only while the pipe is empty.
//   An accepted word moves through the stages in order, the last being the output register.
//   Throughput: one word per cycle unless stalled, set by the three register stages
//   (products, position/ramp/deltas, velocity sums into the output register).
//   Each stage moves when it is empty or the one after it moves, so bubbles
//   close up while the output stalls; in_ready_o falls only when all three
//   stages hold a word and the receiver is not taking one.
//   Reset clears all stage valid bits; frame_time and current_time reset to 0,
//   gravity to 800.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module particle_update_step import pu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [39:0]  cfg_data_i,

  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [2:0]   ptype_i,
  input  logic [15:0]  ramp_in_i,
  input  logic [7:0]   color_in_i,
  input  logic [31:0]  pos_x_i,
  input  logic [31:0]  pos_y_i,
  input  logic [31:0]  pos_z_i,
  input  logic [31:0]  vel_x_i,
  input  logic [31:0]  vel_y_i,
  input  logic [31:0]  vel_z_i,
  input  logic [39:0]  death_time_i,

  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         removed_o,
  output logic         expire_next_o,
  output logic [15:0]  ramp_out_o,
  output logic [7:0]   color_out_o,
  output logic [31:0]  new_pos_x_o,
  output logic [31:0]  new_pos_y_o,
  output logic [31:0]  new_pos_z_o,
  output logic [31:0]  new_vel_x_o,
  output logic [31:0]  new_vel_y_o,
  output logic [31:0]  new_vel_z_o
);

  logic [15:0] frame_time_q;
  logic [11:0] gravity_q;
  logic [39:0] current_time_q;
  cfg_t        cfg;
  in_t         in_word;
  s1_t         s1_data;
  s2_t         s2_data;
  out_t        out_data;
  logic        s1_valid, s2_valid;
  logic        en1, en2, en3;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_time_q   <= '0;
      gravity_q      <= GRAVITY_RESET;
      current_time_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_TIME:   frame_time_q   <= cfg_data_i[15:0];
        CFG_GRAVITY:      gravity_q      <= cfg_data_i[11:0];
        CFG_CURRENT_TIME: current_time_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.ft   = frame_time_q;
  assign cfg.grav = gravity_q;
  assign cfg.now  = current_time_q;

  assign in_word.ptype  = ptype_e'(ptype_i);
  assign in_word.ramp   = ramp_in_i;
  assign in_word.color  = color_in_i;
  assign in_word.pos[0] = pos_x_i;
  assign in_word.pos[1] = pos_y_i;
  assign in_word.pos[2] = pos_z_i;
  assign in_word.vel[0] = vel_x_i;
  assign in_word.vel[1] = vel_y_i;
  assign in_word.vel[2] = vel_z_i;
  assign in_word.death  = death_time_i;

  // stage enables: a stage loads when empty or when its word moves on
  assign en3        = !out_valid_o || out_ready_i;
  assign en2        = !s2_valid || en3;
  assign en1        = !s1_valid || en2;
  assign in_ready_o = en1;

  pu_prod_stage u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .data_i  (in_word),
    .valid_o (s1_valid),
    .data_o  (s1_data)
  );

  pu_update_stage u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  pu_vel_stage u_vel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .data_o  (out_data)
  );

  assign removed_o     = out_data.removed;
  assign expire_next_o = out_data.expire;
  assign ramp_out_o    = out_data.ramp;
  assign color_out_o   = out_data.color;
  assign new_pos_x_o   = out_data.pos[0];
  assign new_pos_y_o   = out_data.pos[1];
  assign new_pos_z_o   = out_data.pos[2];
  assign new_vel_x_o   = out_data.vel[0];
  assign new_vel_y_o   = out_data.vel[1];
  assign new_vel_z_o   = out_data.vel[2];

  // back-pressure only when every stage is occupied
  `ASSERT_IMPL(a_full_stall, !in_ready_o, s1_valid && s2_valid && out_valid_o && !out_ready_i, "in_ready low with a free stage")
  `ASSERT_NEXT(a_accept_lands, in_valid_i && in_ready_o, s1_valid, "accepted word not in stage 1")
  `ASSERT_IMPL(a_removed_no_expire, out_valid_o && removed_o, !expire_next_o, "removed word flagged to expire")
  `ASSERT_IMPL(a_expire_ramp, out_valid_o && expire_next_o, ramp_out_o >= RAMP_LIMIT_FIRE, "expire below ramp limit")

endmodule

/* sim/particle_update_step_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for particle_update_step: directed and random particle words
// are checked against a predictor built into the bench. Depends on pu_pkg and the RTL.

module particle_update_step_test;
  import pu_pkg::*;

  localparam int PipeLatency = 3;
  localparam int ItemsPerPhase = 175;
  localparam int RandomPhases = 6;
  localparam int HoldOffCycles = 80;
  localparam int CycleLimit = 400000;
  localparam logic [39:0] TimeMax = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] WordMax = 32'h7FFF_FFFF;
  localparam logic [31:0] WordMin = 32'h8000_0000;
  localparam logic [1:0] CfgIdxSpare = 2'd3;
  // color ramps, entry 0 in the top byte
  localparam logic [63:0] FireColors = 64'h6d6b_0605_0403_0000;
  localparam logic [63:0] ExplodeColors = 64'h6f6d_6b69_6765_6361;
  localparam logic [63:0] Explode2Colors = 64'h6f6e_6d6c_6b6a_6866;

  typedef struct packed {
    ptype_e             ptype;
    logic [15:0]        ramp_in;
    logic [7:0]         color_in;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic [39:0]        death_time;
  } particle_rec_t;

  typedef struct packed {
    logic        removed;
    logic        expire_next;
    logic [15:0] ramp_out;
    logic [7:0]  color_out;
    logic [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic [31:0] new_vel_x, new_vel_y, new_vel_z;
  } update_t;

  function automatic logic [31:0] clamp_word(longint v);
    if (v > 64'sd2147483647) return WordMax;
    if (v < -64'sd2147483648) return WordMin;
    return v[31:0];
  endfunction

  function automatic logic [7:0] ramp_color(ptype_e t, logic [2:0] idx);
    logic [63:0] row;
    case (t)
      KIND_FIRE:    row = FireColors;
      KIND_EXPLODE: row = ExplodeColors;
      default:      row = Explode2Colors;
    endcase
    return row[63 - 8 * int'(idx) -: 8];
  endfunction

  class update_scoreboard;
    logic [15:0] frame_time;
    logic [11:0] gravity_val;
    logic [39:0] current_time;
    update_t pending_updates[$];
    int errors;
    int checked;
    int removed_seen;
    int expired_seen;

    function new();
      frame_time = '0;
      gravity_val = 12'd800;
      current_time = '0;
      errors = 0;
      checked = 0;
      removed_seen = 0;
      expired_seen = 0;
    endfunction

    function void apply_register(logic [1:0] idx, logic [39:0] data);
      case (idx)
        CFG_FRAME_TIME:   frame_time = data[15:0];
        CFG_GRAVITY:      gravity_val = data[11:0];
        CFG_CURRENT_TIME: current_time = data;
        default: ;
      endcase
    endfunction

    function update_t predict_update(particle_rec_t p);
      update_t r;
      longint pos[3];
      longint vel[3];
      longint nv[3];
      longint ft;
      longint grav;
      int ramp_sum;
      int k;
      logic [15:0] limit;
      int i;
      pos[0] = p.pos_x;
      pos[1] = p.pos_y;
      pos[2] = p.pos_z;
      vel[0] = p.vel_x;
      vel[1] = p.vel_y;
      vel[2] = p.vel_z;
      r.removed = 1'b0;
      r.expire_next = 1'b0;
      r.ramp_out = p.ramp_in;
      r.color_out = p.color_in;
      if (p.death_time < current_time) begin
        // dead particle goes back untouched
        r.removed = 1'b1;
      end else begin
        ft = longint'(frame_time);
        grav = ft * longint'(gravity_val) / 20;
        for (i = 0; i < 3; i++) begin
          nv[i] = vel[i];
          pos[i] = pos[i] + ((vel[i] * ft) >>> 16);
        end
        case (p.ptype)
          KIND_FIRE: begin
            k = 5;
            limit = 16'h6000;
          end
          KIND_EXPLODE: begin
            k = 10;
            limit = 16'h8000;
          end
          KIND_EXPLODE2: begin
            k = 15;
            limit = 16'h8000;
          end
          default: begin
            k = 0;
            limit = '0;
          end
        endcase
        if (k != 0) begin
          ramp_sum = int'(p.ramp_in) + ((int'(frame_time) * k) >> 4);
          if (ramp_sum > 65535) ramp_sum = 65535;
          r.ramp_out = ramp_sum[15:0];
          if (r.ramp_out >= limit) begin
            r.expire_next = 1'b1;
          end else begin
            r.color_out = ramp_color(p.ptype, r.ramp_out[14:12]);
          end
        end
        case (p.ptype)
          KIND_GRAV, KIND_SLOWGRAV: nv[2] = nv[2] - grav;
          KIND_FIRE: nv[2] = nv[2] + grav;
          KIND_EXPLODE, KIND_BLOB: begin
            for (i = 0; i < 3; i++) nv[i] = nv[i] + ((vel[i] * ft * 4) >>> 16);
            nv[2] = nv[2] - grav;
          end
          KIND_EXPLODE2: begin
            for (i = 0; i < 3; i++) nv[i] = nv[i] - ((vel[i] * ft) >>> 16);
            nv[2] = nv[2] - grav;
          end
          KIND_BLOB2: begin
            for (i = 0; i < 2; i++) nv[i] = nv[i] - ((vel[i] * ft * 4) >>> 16);
            nv[2] = nv[2] - grav;
          end
          default: ;
        endcase
      end
      if (r.removed) begin
        r.new_pos_x = p.pos_x;
        r.new_pos_y = p.pos_y;
        r.new_pos_z = p.pos_z;
        r.new_vel_x = p.vel_x;
        r.new_vel_y = p.vel_y;
        r.new_vel_z = p.vel_z;
      end else begin
        r.new_pos_x = clamp_word(pos[0]);
        r.new_pos_y = clamp_word(pos[1]);
        r.new_pos_z = clamp_word(pos[2]);
        r.new_vel_x = clamp_word(nv[0]);
        r.new_vel_y = clamp_word(nv[1]);
        r.new_vel_z = clamp_word(nv[2]);
      end
      return r;
    endfunction

    function void note_particle(particle_rec_t p);
      pending_updates.push_back(predict_update(p));
    endfunction

    function void compare_field(string name, logic [39:0] want_v, logic [39:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_update(update_t got);
      update_t want;
      if (pending_updates.size() == 0) begin
        $display("%0t: output word with nothing expected", $time);
        errors++;
      end else begin
        want = pending_updates.pop_front();
        checked++;
        if (want.removed) removed_seen++;
        if (want.expire_next) expired_seen++;
        compare_field("removed", 40'(want.removed), 40'(got.removed));
        compare_field("expire_next", 40'(want.expire_next), 40'(got.expire_next));
        compare_field("ramp_out", 40'(want.ramp_out), 40'(got.ramp_out));
        compare_field("color_out", 40'(want.color_out), 40'(got.color_out));
        compare_field("new_pos_x", 40'(want.new_pos_x), 40'(got.new_pos_x));
        compare_field("new_pos_y", 40'(want.new_pos_y), 40'(got.new_pos_y));
        compare_field("new_pos_z", 40'(want.new_pos_z), 40'(got.new_pos_z));
        compare_field("new_vel_x", 40'(want.new_vel_x), 40'(got.new_vel_x));
        compare_field("new_vel_y", 40'(want.new_vel_y), 40'(got.new_vel_y));
        compare_field("new_vel_z", 40'(want.new_vel_z), 40'(got.new_vel_z));
      end
    endfunction

    function int pending();
      return pending_updates.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [39:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  ptype_i;
  logic [15:0] ramp_in_i;
  logic [7:0]  color_in_i;
  logic [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic [31:0] vel_x_i, vel_y_i, vel_z_i;
  logic [39:0] death_time_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        removed_o;
  logic        expire_next_o;
  logic [15:0] ramp_out_o;
  logic [7:0]  color_out_o;
  logic [31:0] new_pos_x_o, new_pos_y_o, new_pos_z_o;
  logic [31:0] new_vel_x_o, new_vel_y_o, new_vel_z_o;

  update_scoreboard sb;
  bit idle_on;
  bit hold_off_req;
  int hold_offs;
  int cfg_writes;

  particle_update_step DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [31:0] rand_word();
    logic [19:0] lo;
    int sel;
    sel = $urandom_range(0, 99);
    lo = 20'($urandom);
    if (sel < 60) return $urandom;
    if (sel < 82) return {{12{lo[19]}}, lo};
    case ($urandom_range(0, 3))
      0: return WordMax;
      1: return WordMin;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // death times cluster around now so both outcomes show up often
  function automatic logic [39:0] rand_death(logic [39:0] now);
    case ($urandom_range(0, 9))
      0: return now - 40'd1;
      1: return now;
      2: return now + 40'd1;
      3: return '0;
      4: return TimeMax;
      5: return rand40();
      default: return now + {20'd0, 20'($urandom)};
    endcase
  endfunction

  function automatic particle_rec_t make_particle(ptype_e t, logic [15:0] ramp,
      logic [7:0] color,
      logic [31:0] px, logic [31:0] py, logic [31:0] pz,
      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [39:0] death);
    particle_rec_t p;
    p.ptype = t;
    p.ramp_in = ramp;
    p.color_in = color;
    p.pos_x = px;
    p.pos_y = py;
    p.pos_z = pz;
    p.vel_x = vx;
    p.vel_y = vy;
    p.vel_z = vz;
    p.death_time = death;
    return p;
  endfunction

  function automatic particle_rec_t rand_particle(logic [39:0] now);
    logic [15:0] ramp;
    if ($urandom_range(0, 1) == 0) ramp = 16'($urandom_range(0, 16'h7FFF));
    else ramp = 16'($urandom);
    return make_particle(ptype_e'($urandom_range(0, 7)), ramp, 8'($urandom),
                         rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_word(), rand_death(now));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic configure(logic [15:0] ft, logic [11:0] grav, logic [39:0] now, bit ft_only);
    logic [1:0]  idx [4];
    logic [39:0] val [4];
    int n;
    idx[0] = CFG_FRAME_TIME;
    idx[1] = CFG_GRAVITY;
    idx[2] = CFG_CURRENT_TIME;
    idx[3] = CfgIdxSpare;
    val[0] = 40'(ft);
    val[1] = 40'(grav);
    val[2] = now;
    val[3] = rand40();
    n = ft_only ? 1 : 4;
    for (int i = 0; i < n; i++) begin
      cfg_index_i = idx[i];
      cfg_data_i = val[i];
      cfg_valid_i = 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.apply_register(idx[i], val[i]);
      cfg_writes++;
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
  endtask

  // leaves valid high; the next call or the caller lowers it
  task automatic send_particle(particle_rec_t p);
    int gap;
    gap = 0;
    if (idle_on && !hold_off_req && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ptype_i = p.ptype;
    ramp_in_i = p.ramp_in;
    color_in_i = p.color_in;
    pos_x_i = p.pos_x;
    pos_y_i = p.pos_y;
    pos_z_i = p.pos_z;
    vel_x_i = p.vel_x;
    vel_y_i = p.vel_y;
    vel_z_i = p.vel_z;
    death_time_i = p.death_time;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_particle(p);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        // long stall so the pipe fills and backs up into the input
        out_ready_i = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
        hold_offs++;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i = 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    update_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.removed = removed_o;
      got.expire_next = expire_next_o;
      got.ramp_out = ramp_out_o;
      got.color_out = color_out_o;
      got.new_pos_x = new_pos_x_o;
      got.new_pos_y = new_pos_y_o;
      got.new_pos_z = new_pos_z_o;
      got.new_vel_x = new_vel_x_o;
      got.new_vel_y = new_vel_y_o;
      got.new_vel_z = new_vel_z_o;
      sb.check_update(got);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: no finish after %0d cycles, %0d words outstanding",
             $time, CycleLimit, sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] ft;
    logic [11:0] grav;
    logic [39:0] now;
    sb = new();
    idle_on = 1'b1;
    hold_off_req = 1'b0;
    hold_offs = 0;
    cfg_writes = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    ptype_i = '0;
    ramp_in_i = '0;
    color_in_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    vel_x_i = '0;
    vel_y_i = '0;
    vel_z_i = '0;
    death_time_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // only frame time set: gravity and current time must hold their reset values
    configure(16'h0444, 12'd0, 40'd0, 1'b1);
    send_particle(make_particle(KIND_GRAV, 16'h0000, 8'h11, 32'h000A_0000, 32'h0014_0000,
                                32'h001E_0000, 32'h0001_0000, 32'hFFFE_0000,
                                32'h0005_0000, 40'd100));
    send_particle(make_particle(KIND_FIRE, 16'h1800, 8'h22, 32'hFFF0_0000, 32'h0000_8000,
                                32'h0003_0000, 32'h0040_0000, 32'h0000_1234,
                                32'hFF80_0000, 40'd0));
    send_particle(make_particle(KIND_EXPLODE, 16'h0000, 8'h33, 32'h0100_0000, 32'h0,
                                32'h0, 32'h0020_0000, 32'hFFE0_0000, 32'h0010_0000,
                                40'd7));
    send_particle(make_particle(KIND_BLOB2, 16'h2345, 8'h44, 32'h0, 32'h1234_5678,
                                32'hEDCB_A988, 32'h0030_0000, 32'hFFD0_0000,
                                32'h0002_0000, TimeMax));
    in_valid_i = 1'b0;
    drain_pipeline();

    // largest frame time and gravity, now = 1000
    configure(16'hFFFF, 12'hFFF, 40'd1000, 1'b0);
    for (int t = 0; t < 8; t++) begin
      send_particle(make_particle(ptype_e'(t), 16'h1000, 8'h20, 32'h0001_0000,
                                  32'hFFFD_0000, 32'h0005_0000, 32'h0002_0000,
                                  32'hFFF9_0000, 32'h0009_0000, 40'd5000));
    end
    // past death time: removed, passed through
    send_particle(make_particle(KIND_FIRE, 16'h1000, 8'h55, 32'h0001_0000, 32'h2,
                                32'h3, WordMax, WordMin, 32'h7, 40'd999));
    send_particle(make_particle(KIND_EXPLODE, 16'hFFFF, 8'hAA, WordMin, WordMax,
                                32'hFFFF_FFFF, 32'h1, 32'h0, WordMax, 40'd0));
    // death time equal to now is still alive
    send_particle(make_particle(KIND_BLOB2, 16'h0100, 8'h01, 32'h0, 32'h0, 32'h0,
                                32'h0100_0000, 32'hFF00_0000, 32'h0, 40'd1000));
    // saturation of position and velocity at both ends
    send_particle(make_particle(KIND_STATIC, 16'h0, 8'h0, WordMax, WordMax, WordMax,
                                WordMax, WordMax, WordMax, TimeMax));
    send_particle(make_particle(KIND_BLOB, 16'h0, 8'h0, WordMax, WordMax, WordMax,
                                WordMax, WordMax, WordMax, TimeMax));
    send_particle(make_particle(KIND_BLOB, 16'h0, 8'h0, WordMin, WordMin, WordMin,
                                WordMin, WordMin, WordMin, TimeMax));
    send_particle(make_particle(KIND_EXPLODE2, 16'h0, 8'h0, WordMin, WordMax, 32'h0,
                                WordMin, WordMin, WordMin, TimeMax));
    send_particle(make_particle(KIND_GRAV, 16'h0, 8'h0, 32'h0, 32'h0, 32'h0,
                                32'h0, 32'h0, WordMin, TimeMax));
    send_particle(make_particle(KIND_FIRE, 16'h0, 8'h0, 32'h0, 32'h0, 32'h0,
                                32'h0, 32'h0, WordMax, TimeMax));
    // ramp runs out; color kept. Second one also saturates the ramp
    send_particle(make_particle(KIND_FIRE, 16'h5000, 8'h77, 32'h0, 32'h0, 32'h0,
                                32'h0, 32'h0, 32'h0, TimeMax));
    send_particle(make_particle(KIND_EXPLODE2, 16'hFFFF, 8'h88, 32'h0, 32'h0, 32'h0,
                                32'h0, 32'h0, 32'h0, TimeMax));
    in_valid_i = 1'b0;
    drain_pipeline();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      ft = 16'($urandom);
      grav = 12'($urandom);
      now = rand40();
      idle_on = 1'b1;
      case (phase)
        1: begin
          ft = '0;
          grav = '0;
          now = '0;
        end
        2: begin
          ft = 16'hFFFF;
          grav = 12'hFFF;
          now = TimeMax;
          idle_on = 1'b0;
        end
        3: begin
          ft = 16'd1092;
          grav = 12'd800;
        end
        4: ft = 16'($urandom_range(0, 4096));
        5: now = 40'($urandom_range(0, 1000));
        default: ;
      endcase
      configure(ft, grav, now, 1'b0);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase == 3 && n == 40) hold_off_req = 1'b1;
        send_particle(rand_particle(sb.current_time));
      end
      in_valid_i = 1'b0;
      drain_pipeline();
    end

    $display("Checked %0d particle words (%0d removed, %0d ramp expiries) over %0d",
             sb.checked, sb.removed_seen, sb.expired_seen, cfg_writes);
    $display("register writes, with %0d long output hold-off(s) and random idling.",
             hold_offs);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pu_pkg.sv
rtl/core/pu_prod_stage.sv
rtl/core/pu_update_stage.sv
rtl/core/pu_vel_stage.sv
rtl/core/particle_update_step.sv
sim/particle_update_step_test.sv
